// ----- src/cbis_pkg.sv -----
// Shared constants for the combination basis index search unit.
`default_nettype none
package cbis_pkg;

  // Default sizing of the table and of one state half
  localparam int CBIS_MAX_SITES   = 8;
  localparam int CBIS_TABLE_DEPTH = 16384;

  // Register reset values
  localparam logic [3:0] CBIS_SITES_RST     = 4'd4;
  localparam logic [4:0] CBIS_PARTICLES_RST = 5'd4;

  // Register indexes (word address bit 2)
  localparam logic CBIS_REG_SITES     = 1'b0;
  localparam logic CBIS_REG_PARTICLES = 1'b1;

  // Item modes
  localparam logic [1:0] CBIS_MODE_BUILD  = 2'd0;
  localparam logic [1:0] CBIS_MODE_READ   = 2'd1;
  localparam logic [1:0] CBIS_MODE_SEARCH = 2'd2;

  // Result status codes
  localparam logic [2:0] CBIS_ST_OK        = 3'd0;
  localparam logic [2:0] CBIS_ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] CBIS_ST_BAD_POP   = 3'd2;
  localparam logic [2:0] CBIS_ST_RANGE     = 3'd3;
  localparam logic [2:0] CBIS_ST_NOT_BUILT = 3'd4;

endpackage
`default_nettype wire

// ----- src/cbis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbis_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- src/cbis_step.sv -----
// Next larger word with the same popcount, plus a check that it fits in 2n bits.
`default_nettype none
module cbis_step #(
  parameter int MAX_SITES = 8
) (
  input  wire logic [2*MAX_SITES-1:0]         word_i,
  input  wire logic [$clog2(MAX_SITES+1):0]   two_n_i,
  output logic      [2*MAX_SITES-1:0]         next_o,
  output logic                                fits_o
);

  localparam int WW  = 2 * MAX_SITES;
  localparam int EW  = WW + 2;
  localparam int TZW = $clog2(WW);

  logic [EW-1:0]  ext;
  logic [EW-1:0]  low;
  logic [EW-1:0]  ripple;
  logic [EW-1:0]  ones;
  logic [EW-1:0]  full;
  logic [TZW-1:0] tz;

  assign ext    = EW'(word_i);
  assign low    = ext & (~ext + EW'(1));
  assign ripple = ext + low;
  assign ones   = ripple ^ ext;

  // lowest set bit is one-hot in low: encode its position
  always_comb begin
    tz = '0;
    for (int i = 0; i < WW; i++) begin
      if (low[i]) begin
        tz = tz | TZW'(i);
      end
    end
  end

  assign full   = ripple | ((ones >> 2) >> tz);
  assign fits_o = ((full >> two_n_i) == '0);
  assign next_o = full[WW-1:0];

endmodule
`default_nettype wire

// ----- src/combination_basis_index_search_unit.sv -----
// Top level of the combination basis index search unit: control, registers, table.
//
// Usage: items enter on in_* (in_valid/in_stall) and each item yields exactly one
// result on out_* (out_valid/out_stall). An item is taken when valid is high and
// stall is low. num_sites and num_particles are written over the APB port
// (offset 0 and 4); any write marks the table as not built.
// Mode 0 builds the table: one entry is written per cycle; a full table at 8 + 8
// sites and 8 particles holds 12870 entries.
// Mode 1 reads one entry; its data passes S_RDWAIT and S_DONE to the output register.
// Mode 2 binary-searches the table: every probe is one table read (S_SRCH)
// plus one compare (S_CMP), one probe at a time on the single table read port.
// One item is worked on at a time; in_stall is high while an item is in work.
// A finished result sits in the output register, so the next item is taken
// while that result still waits for the receiver; a stalled result holds.
// Reset clears size, the built flag and the registers to 4 sites and 4
// particles; the table contents are not cleared and need no clearing pass.
`default_nettype none
module combination_basis_index_search_unit #(
  parameter int MAX_SITES   = cbis_pkg::CBIS_MAX_SITES,
  parameter int TABLE_DEPTH = cbis_pkg::CBIS_TABLE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [13:0] in_state_index,
  input  wire logic [7:0]  in_up_half,
  input  wire logic [7:0]  in_down_half,
  // result item channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [13:0]      out_found_index,
  output logic [7:0]       out_entry_up,
  output logic [7:0]       out_entry_down,
  output logic [13:0]      out_entry_count,
  output logic [2:0]       out_status,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int HW = MAX_SITES;
  localparam int WW = 2 * MAX_SITES;
  localparam int SW = $clog2(MAX_SITES + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(WW + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_BUILD  = 3'd1;
  localparam logic [2:0] S_RDWAIT = 3'd2;
  localparam logic [2:0] S_SRCH   = 3'd3;
  localparam logic [2:0] S_CMP    = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  // control state
  logic [2:0]    state_r, state_nxt;
  logic [3:0]    sites_r, sites_nxt;
  logic [4:0]    parts_r, parts_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic          built_r, built_nxt;
  logic          out_valid_r, out_valid_nxt;

  // working registers
  logic [WW-1:0] w_r, w_nxt;
  logic [CW-1:0] bidx_r, bidx_nxt;
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [WW-1:0] key_r, key_nxt;

  // staged result and output register
  logic [13:0] res_found_r, res_found_nxt;
  logic [7:0]  res_up_r, res_up_nxt;
  logic [7:0]  res_down_r, res_down_nxt;
  logic [2:0]  res_status_r, res_status_nxt;
  logic [13:0] out_found_r, out_found_nxt;
  logic [7:0]  out_up_r, out_up_nxt;
  logic [7:0]  out_down_r, out_down_nxt;
  logic [13:0] out_count_r, out_count_nxt;
  logic [2:0]  out_status_r, out_status_nxt;

  // derived values
  logic [SW-1:0] n_eff;
  logic [SW:0]   two_n;
  logic [HW-1:0] hmask;
  logic [HW-1:0] up_m;
  logic [HW-1:0] dn_m;
  logic [PW-1:0] pop_sum;
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic          in_acc;
  logic          cfg_wr;

  // table port
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  // step unit
  logic [WW-1:0] step_next;
  logic          step_fits;

  assign n_eff   = (32'(sites_r) > MAX_SITES) ? SW'(MAX_SITES) : SW'(sites_r);
  assign two_n   = {n_eff, 1'b0};
  assign hmask   = ~({HW{1'b1}} << n_eff);
  assign up_m    = HW'(in_up_half) & hmask;
  assign dn_m    = HW'(in_down_half) & hmask;
  assign pop_sum = PW'($countones(up_m)) + PW'($countones(dn_m));
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[CW:1];
  assign in_acc  = in_valid && !in_stall;
  assign cfg_wr  = psel && penable && pwrite && pready;

  assign mem_we    = (state_r == S_BUILD);
  assign mem_waddr = bidx_r[AW-1:0];
  assign mem_wdata = w_r;
  // read the entry index on a read item, else the search midpoint
  assign mem_raddr = (state_r == S_IDLE) ? AW'(in_state_index) : mid[AW-1:0];

  cbis_ram #(
    .WIDTH (WW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  cbis_step #(
    .MAX_SITES (MAX_SITES)
  ) u_step (
    .word_i  (w_r),
    .two_n_i (two_n),
    .next_o  (step_next),
    .fits_o  (step_fits)
  );

  always_comb begin
    state_nxt      = state_r;
    sites_nxt      = sites_r;
    parts_nxt      = parts_r;
    size_nxt       = size_r;
    built_nxt      = built_r;
    w_nxt          = w_r;
    bidx_nxt       = bidx_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    key_nxt        = key_r;
    res_found_nxt  = res_found_r;
    res_up_nxt     = res_up_r;
    res_down_nxt   = res_down_r;
    res_status_nxt = res_status_r;
    out_found_nxt  = out_found_r;
    out_up_nxt     = out_up_r;
    out_down_nxt   = out_down_r;
    out_count_nxt  = out_count_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r;

    // drop the result once the receiver takes it
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_found_nxt  = '0;
          res_up_nxt     = '0;
          res_down_nxt   = '0;
          res_status_nxt = cbis_pkg::CBIS_ST_OK;
          state_nxt      = S_DONE;
          case (in_mode)
            cbis_pkg::CBIS_MODE_BUILD: begin
              if (32'(parts_r) > 32'(two_n)) begin
                // more particles than bits: empty table
                size_nxt  = '0;
                built_nxt = 1'b1;
              end else begin
                w_nxt     = ~({WW{1'b1}} << parts_r);
                bidx_nxt  = '0;
                state_nxt = S_BUILD;
              end
            end
            cbis_pkg::CBIS_MODE_READ: begin
              if (!built_r) begin
                res_status_nxt = cbis_pkg::CBIS_ST_NOT_BUILT;
              end else if (32'(in_state_index) >= 32'(size_r)) begin
                res_status_nxt = cbis_pkg::CBIS_ST_RANGE;
              end else begin
                state_nxt = S_RDWAIT;
              end
            end
            cbis_pkg::CBIS_MODE_SEARCH: begin
              if (!built_r) begin
                res_status_nxt = cbis_pkg::CBIS_ST_NOT_BUILT;
              end else if (32'(pop_sum) != 32'(parts_r)) begin
                res_status_nxt = cbis_pkg::CBIS_ST_BAD_POP;
              end else begin
                key_nxt   = (WW'(up_m) << n_eff) | WW'(dn_m);
                lo_nxt    = '0;
                hi_nxt    = size_r;
                state_nxt = S_SRCH;
              end
            end
            default: begin
              res_status_nxt = cbis_pkg::CBIS_ST_OK;
            end
          endcase
        end
      end
      S_BUILD: begin
        // the entry at bidx_r is written this cycle
        if (parts_r == '0 || !step_fits) begin
          size_nxt  = bidx_r + CW'(1);
          built_nxt = 1'b1;
          state_nxt = S_DONE;
        end else if (32'(bidx_r) + 1 == TABLE_DEPTH) begin
          size_nxt       = CW'(TABLE_DEPTH);
          built_nxt      = 1'b1;
          res_status_nxt = cbis_pkg::CBIS_ST_RANGE;
          state_nxt      = S_DONE;
        end else begin
          bidx_nxt = bidx_r + CW'(1);
          w_nxt    = step_next;
        end
      end
      S_RDWAIT: begin
        res_up_nxt   = 8'(mem_rdata >> n_eff);
        res_down_nxt = 8'(mem_rdata[HW-1:0] & hmask);
        state_nxt    = S_DONE;
      end
      S_SRCH: begin
        if (lo_r >= hi_r) begin
          res_status_nxt = cbis_pkg::CBIS_ST_NOT_FOUND;
          state_nxt      = S_DONE;
        end else begin
          // probe issued at mid this cycle
          mid_nxt   = mid;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (mem_rdata < key_r) begin
          lo_nxt    = mid_r + CW'(1);
          state_nxt = S_SRCH;
        end else if (mem_rdata > key_r) begin
          hi_nxt    = mid_r;
          state_nxt = S_SRCH;
        end else begin
          res_found_nxt = 14'(mid_r);
          state_nxt     = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_found_nxt  = res_found_r;
          out_up_nxt     = res_up_r;
          out_down_nxt   = res_down_r;
          out_count_nxt  = 14'(size_r);
          out_status_nxt = res_status_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register writes invalidate the table
    if (cfg_wr) begin
      built_nxt = 1'b0;
      if (paddr[2] == cbis_pkg::CBIS_REG_SITES) begin
        sites_nxt = pwdata[3:0];
      end else begin
        parts_nxt = pwdata[4:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sites_r     <= cbis_pkg::CBIS_SITES_RST;
      parts_r     <= cbis_pkg::CBIS_PARTICLES_RST;
      size_r      <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sites_r     <= sites_nxt;
      parts_r     <= parts_nxt;
      size_r      <= size_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    bidx_r       <= bidx_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    key_r        <= key_nxt;
    res_found_r  <= res_found_nxt;
    res_up_r     <= res_up_nxt;
    res_down_r   <= res_down_nxt;
    res_status_r <= res_status_nxt;
    out_found_r  <= out_found_nxt;
    out_up_r     <= out_up_nxt;
    out_down_r   <= out_down_nxt;
    out_count_r  <= out_count_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found_index = out_found_r;
  assign out_entry_up    = out_up_r;
  assign out_entry_down  = out_down_r;
  assign out_entry_count = out_count_r;
  assign out_status      = out_status_r;
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == cbis_pkg::CBIS_REG_SITES) ? {28'd0, sites_r}
                                                                 : {27'd0, parts_r};

`ifndef ASSERT_OFF
  // every search probe lands inside the built table
  a_probe_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH && lo_r < hi_r) |-> (mid < size_r))
    else $error("search probe beyond table size");

  // the search window never inverts or grows past the table
  a_window_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SRCH || state_r == S_CMP) |-> (lo_r <= hi_r && hi_r <= size_r))
    else $error("search window out of order");

  // a finished build marks the table usable
  a_build_marks_built: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_BUILD && state_nxt == S_DONE) |=> built_r)
    else $error("build finished without built flag");

  // build writes stay below the table depth
  a_build_addr: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (32'(bidx_r) < TABLE_DEPTH))
    else $error("build write beyond table depth");
`endif

endmodule
`default_nettype wire

// ----- test/combination_basis_index_search_unit_tb.sv -----
// Self-checking testbench for the combination basis index search unit.
`timescale 1ns / 1ps
module combination_basis_index_search_unit_tb;

  // Mode 3 does nothing but answer with the current count.
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] ADDR_SITES = {cbis_pkg::CBIS_REG_SITES, 2'b00};
  localparam logic [2:0] ADDR_PARTICLES = {cbis_pkg::CBIS_REG_PARTICLES, 2'b00};
  localparam int RANDOM_ITEMS = 1875;
  // Longest quiet stretch: a full 8+8 site build plus stalls, several times over.
  localparam int IDLE_LIMIT = 60000;
  localparam int TAIL_CYCLES = 100;
  localparam int SMALL_TABLE = 1000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [13:0] sidx;
    logic [7:0]  up;
    logic [7:0]  dn;
  } item_t;

  typedef struct packed {
    logic [13:0] found;
    logic [7:0]  eup;
    logic [7:0]  edn;
    logic [13:0] count;
    logic [2:0]  status;
  } result_t;

  typedef struct {
    bit         is_cfg;
    bit         typed;
    logic [3:0] sites;
    logic [4:0] parts;
    item_t      item;
    result_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [13:0] in_state_index;
  logic [7:0]  in_up_half;
  logic [7:0]  in_down_half;
  logic        out_valid;
  logic        out_stall;
  logic [13:0] out_found_index;
  logic [7:0]  out_entry_up;
  logic [7:0]  out_entry_down;
  logic [13:0] out_entry_count;
  logic [2:0]  out_status;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Predicted block state: registers, table copy, size and built flag.
  logic [3:0]  model_sites;
  logic [4:0]  model_parts;
  logic [15:0] basis_copy [cbis_pkg::CBIS_TABLE_DEPTH];
  int unsigned model_size;
  bit          model_built;

  result_t     pending_results [$];
  stim_row_t   stim_rows [$];
  int          mismatch_count;
  bit          tx_quiet;
  bit          rx_quiet;
  int          rx_hold;
  int          stall_left;

  wire in_take  = in_valid && !in_stall;
  wire out_take = out_valid && !out_stall;

  combination_basis_index_search_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_mode         (in_mode),
    .in_state_index  (in_state_index),
    .in_up_half      (in_up_half),
    .in_down_half    (in_down_half),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_found_index (out_found_index),
    .out_entry_up    (out_entry_up),
    .out_entry_down  (out_entry_down),
    .out_entry_count (out_entry_count),
    .out_status      (out_status),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Number of 2n-bit words with k set bits, i.e. the table size a build yields.
  function automatic longint unsigned word_count(int unsigned bits, int unsigned ones);
    longint unsigned r;
    r = 1;
    if (ones > bits) return 0;
    for (int unsigned i = 1; i <= ones; i++) r = r * (bits - ones + i) / i;
    return r;
  endfunction

  // Next larger word with the same popcount; w must be nonzero.
  function automatic logic [63:0] next_word(logic [63:0] w);
    logic [63:0] lowest;
    logic [63:0] ripple;
    logic [63:0] ones;
    int tz;
    lowest = w & (~w + 64'd1);
    ripple = w + lowest;
    ones = ripple ^ w;
    tz = 0;
    while (!lowest[tz] && tz < 63) tz++;
    return ripple | ((ones >> 2) >> tz);
  endfunction

  function automatic int unsigned half_width();
    return (model_sites > cbis_pkg::CBIS_MAX_SITES) ? cbis_pkg::CBIS_MAX_SITES : model_sites;
  endfunction

  function automatic logic [7:0] half_mask(int unsigned n);
    return (n >= 8) ? 8'hFF : 8'((1 << n) - 1);
  endfunction

  // Work out the result of one accepted item and advance the predicted state.
  function automatic result_t basis_predict(item_t it);
    result_t r;
    int unsigned n;
    longint unsigned total;
    logic [63:0] w;
    logic [63:0] key;
    logic [7:0] hmask;
    logic [7:0] up;
    logic [7:0] dn;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '0;
    n = half_width();
    hmask = half_mask(n);
    case (it.mode)
      cbis_pkg::CBIS_MODE_BUILD: begin
        total = word_count(2 * n, model_parts);
        if (total > cbis_pkg::CBIS_TABLE_DEPTH) begin
          total = cbis_pkg::CBIS_TABLE_DEPTH;
          r.status = cbis_pkg::CBIS_ST_RANGE;
        end
        // Start from the lowest bits set and step through the same popcount.
        w = (64'd1 << model_parts) - 64'd1;
        for (longint unsigned i = 0; i < total; i++) begin
          basis_copy[i] = w[15:0];
          if (i + 1 < total) w = next_word(w);
        end
        model_size = int'(total);
        model_built = 1'b1;
      end
      cbis_pkg::CBIS_MODE_READ: begin
        if (!model_built) begin
          r.status = cbis_pkg::CBIS_ST_NOT_BUILT;
        end else if (it.sidx >= model_size) begin
          r.status = cbis_pkg::CBIS_ST_RANGE;
        end else begin
          w = 64'(basis_copy[it.sidx]);
          r.eup = 8'(w >> n);
          r.edn = w[7:0] & hmask;
        end
      end
      cbis_pkg::CBIS_MODE_SEARCH: begin
        // Bits above the half width play no part.
        up = it.up & hmask;
        dn = it.dn & hmask;
        if (!model_built) begin
          r.status = cbis_pkg::CBIS_ST_NOT_BUILT;
        end else if ($countones(up) + $countones(dn) != model_parts) begin
          r.status = cbis_pkg::CBIS_ST_BAD_POP;
        end else begin
          key = (64'(up) << n) | 64'(dn);
          r.status = cbis_pkg::CBIS_ST_NOT_FOUND;
          lo = 0;
          hi = model_size;
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            if (64'(basis_copy[mid]) < key) begin
              lo = mid + 1;
            end else if (64'(basis_copy[mid]) > key) begin
              hi = mid;
            end else begin
              r.found = 14'(mid);
              r.status = cbis_pkg::CBIS_ST_OK;
              break;
            end
          end
        end
      end
      default: ;
    endcase
    r.count = 14'(model_size);
    return r;
  endfunction

  // Mostly well-formed reads and searches on the current table, some noise.
  function automatic item_t random_item();
    item_t it;
    int unsigned n;
    int unsigned pick;
    logic [15:0] e;
    logic [7:0] hmask;
    n = half_width();
    hmask = half_mask(n);
    it.sidx = 14'($urandom);
    it.up = 8'($urandom);
    it.dn = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it.mode = cbis_pkg::CBIS_MODE_BUILD;
    end else if (pick < 8) begin
      it.mode = MODE_UNUSED;
    end else if (pick < 45) begin
      it.mode = cbis_pkg::CBIS_MODE_READ;
      pick = $urandom_range(0, 9);
      if (pick < 8 && model_size > 0) begin
        it.sidx = 14'($urandom_range(0, model_size - 1));
      end else if (pick < 9) begin
        it.sidx = 14'(model_size + $urandom_range(0, 3));
      end
    end else begin
      it.mode = cbis_pkg::CBIS_MODE_SEARCH;
      if ($urandom_range(0, 3) != 0 && model_size > 0) begin
        e = basis_copy[$urandom_range(0, model_size - 1)];
        it.up = 8'(e >> n);
        it.dn = e[7:0] & hmask;
        // Salt the ignored upper bits now and then.
        if ($urandom_range(0, 3) == 0) begin
          it.up = it.up | (8'($urandom) & ~hmask);
          it.dn = it.dn | (8'($urandom) & ~hmask);
        end
      end
    end
    return it;
  endfunction

  function automatic stim_row_t cfg_row(logic [3:0] s, logic [4:0] p);
    stim_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.sites = s;
    row.parts = p;
    return row;
  endfunction

  function automatic stim_row_t item_row(logic [1:0] m, logic [13:0] idx,
                                         logic [7:0] u, logic [7:0] d);
    stim_row_t row;
    row = '{default: '0};
    row.item.mode = m;
    row.item.sidx = idx;
    row.item.up = u;
    row.item.dn = d;
    return row;
  endfunction

  function automatic stim_row_t checked_row(logic [1:0] m, logic [13:0] idx,
                                            logic [7:0] u, logic [7:0] d,
                                            logic [13:0] f, logic [7:0] eu,
                                            logic [7:0] ed, logic [13:0] c,
                                            logic [2:0] st);
    stim_row_t row;
    row = item_row(m, idx, u, d);
    row.typed = 1'b1;
    row.want.found = f;
    row.want.eup = eu;
    row.want.edn = ed;
    row.want.count = c;
    row.want.status = st;
    return row;
  endfunction

  // Offer one item after a random gap; hold it until taken, then log its result.
  // Enter and leave at a falling edge.
  task automatic send_item(item_t it, bit typed, result_t want);
    int gap;
    result_t predicted;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode = it.mode;
    in_state_index = it.sidx;
    in_up_half = it.up;
    in_down_half = it.dn;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = basis_predict(it);
    pending_results.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  // Drop valid and hold until every logged result has come back.
  task automatic wait_all_results();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // One APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(logic [2:0] addr, logic [31:0] data);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = addr;
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  // Reconfigure only while idle; any write marks the table as not built.
  task automatic write_registers(logic [3:0] s, logic [4:0] p, bit do_sites, bit do_parts);
    logic [31:0] data;
    wait_all_results();
    if (do_sites) begin
      data = $urandom;
      data[3:0] = s;
      write_reg(ADDR_SITES, data);
      model_sites = s;
      model_built = 1'b0;
    end
    if (do_parts) begin
      data = $urandom;
      data[4:0] = p;
      write_reg(ADDR_PARTICLES, data);
      model_parts = p;
      model_built = 1'b0;
    end
  endtask

  // Receiver: long hold-off first, then the per-item stall while a result waits.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_stall = 1'b1;
        rx_hold--;
      end else if (out_valid && stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare every taken result with the oldest one logged.
  always @(posedge clk) begin
    result_t seen;
    result_t want;
    if (rst_n && out_take) begin
      seen.found = out_found_index;
      seen.eup = out_entry_up;
      seen.edn = out_entry_down;
      seen.count = out_entry_count;
      seen.status = out_status;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with nothing outstanding: found=%0d up=%h down=%h count=%0d st=%0d",
                   $realtime, seen.found, seen.eup, seen.edn, seen.count, seen.status);
      end else begin
        want = pending_results.pop_front();
        if (seen.found !== want.found || seen.eup !== want.eup || seen.edn !== want.edn ||
            seen.count !== want.count || seen.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected found=%0d up=%h down=%h count=%0d st=%0d",
                     want.found, want.eup, want.edn, want.count, want.status);
            $display("  actual   found=%0d up=%h down=%h count=%0d st=%0d",
                     seen.found, seen.eup, seen.edn, seen.count, seen.status);
          end
        end
      end
      stall_left = rx_quiet ? 0 : $urandom_range(0, 19);
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (in_take || out_take) idle = 0;
      else idle++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int sent;
    int phase;
    int which;
    int attempts;
    int big_left;
    int burst;
    logic [3:0] s;
    logic [4:0] p;
    int unsigned neff;
    longint unsigned size;
    item_t build_it;

    // Drive every input to a known value from time zero.
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_mode = cbis_pkg::CBIS_MODE_BUILD;
    in_state_index = '0;
    in_up_half = '0;
    in_down_half = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatch_count = 0;
    rx_hold = 0;
    stall_left = 0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
    model_sites = cbis_pkg::CBIS_SITES_RST;
    model_parts = cbis_pkg::CBIS_PARTICLES_RST;
    model_size = 0;
    model_built = 1'b0;

    // Directed rows: reset state, extremes, each status but not-found, sites cap, empty table.
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd0, cbis_pkg::CBIS_ST_NOT_BUILT));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h0F, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd0, cbis_pkg::CBIS_ST_NOT_BUILT));
    stim_rows.push_back(checked_row(MODE_UNUSED, 14'h3FFF, 8'hFF, 8'hFF,
                                    14'd0, 8'h00, 8'h00, 14'd0, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_BUILD, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h0F, 14'd70, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd69, 8'h00, 8'h00,
                                    14'd0, 8'h0F, 8'h00, 14'd70, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd70, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_RANGE));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'h3FFF, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_RANGE));
    // Upper half bits beyond the width drop out of the key.
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'hFF, 8'h00,
                                    14'd69, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h00, 8'hFF,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h01, 8'h01,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_BAD_POP));
    stim_rows.push_back(item_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h03, 8'h05));
    stim_rows.push_back(cfg_row(4'd8, 5'd8));
    // Size survives a register write, the built flag does not.
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_NOT_BUILT));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h0F, 8'h0F,
                                    14'd0, 8'h00, 8'h00, 14'd70, cbis_pkg::CBIS_ST_NOT_BUILT));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_BUILD, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd12870, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'hFF, 14'd12870, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd12869, 8'h00, 8'h00,
                                    14'd0, 8'hFF, 8'h00, 14'd12870, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd12870, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd12870, cbis_pkg::CBIS_ST_RANGE));
    stim_rows.push_back(item_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'hAA, 8'h55));
    // Sites above the cap count as the cap.
    stim_rows.push_back(cfg_row(4'd15, 5'd0));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_BUILD, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd1, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd1, cbis_pkg::CBIS_ST_OK));
    // More particles than bits: the table comes out empty.
    stim_rows.push_back(cfg_row(4'd1, 5'd31));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_BUILD, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd0, cbis_pkg::CBIS_ST_OK));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_READ, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd0, cbis_pkg::CBIS_ST_RANGE));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_SEARCH, 14'd0, 8'h01, 8'h01,
                                    14'd0, 8'h00, 8'h00, 14'd0, cbis_pkg::CBIS_ST_BAD_POP));
    stim_rows.push_back(cfg_row(4'd0, 5'd0));
    stim_rows.push_back(checked_row(cbis_pkg::CBIS_MODE_BUILD, 14'd0, 8'h00, 8'h00,
                                    14'd0, 8'h00, 8'h00, 14'd1, cbis_pkg::CBIS_ST_OK));

    // Hold reset low from time zero, release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].is_cfg)
        write_registers(stim_rows[i].sites, stim_rows[i].parts, 1'b1, 1'b1);
      else
        send_item(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);
    end

    // Random phases: pick a setting, build, then reads and searches on it.
    // Keep most tables small; at most four may exceed SMALL_TABLE entries.
    sent = 0;
    phase = 0;
    big_left = 4;
    while (sent < RANDOM_ITEMS) begin
      phase++;
      which = $urandom_range(0, 3);
      attempts = 0;
      do begin
        attempts++;
        if (attempts > 50) which = 2;
        s = model_sites;
        p = model_parts;
        if (which == 0 || which == 2)
          s = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 5));
        neff = (s > cbis_pkg::CBIS_MAX_SITES) ? cbis_pkg::CBIS_MAX_SITES : s;
        if (which == 1 || which == 2)
          p = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, 2 * neff));
        size = word_count(2 * neff, p);
      end while (size > SMALL_TABLE && big_left == 0);
      if (size > SMALL_TABLE) big_left--;

      // Pause the sender until everything is back, then reconfigure.
      wait_all_results();
      write_registers(s, p, which == 0 || which == 2, which == 1 || which == 2);

      tx_quiet = ($urandom_range(0, 3) == 0);
      rx_quiet = ($urandom_range(0, 3) == 0);
      // Hold the receiver off while items keep coming, so the block backs up.
      if (phase == 3 || phase == 20) rx_hold = 300;

      if ($urandom_range(0, 9) != 0) begin
        build_it.mode = cbis_pkg::CBIS_MODE_BUILD;
        build_it.sidx = 14'($urandom);
        build_it.up = 8'($urandom);
        build_it.dn = 8'($urandom);
        send_item(build_it, 1'b0, '0);
        sent++;
      end
      burst = $urandom_range(15, 50);
      repeat (burst) begin
        send_item(random_item(), 1'b0, '0);
        sent++;
      end
    end

    // Drain, give the block time to misbehave, then report.
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
